// ----- rtl/ramm_pkg.sv -----
// Shared constants and types for the running average motion mask block.
// No dependencies; imported by rtl/ramm_luma.sv and the top level.
package ramm_pkg;

    localparam int PIX_W = 8;
    localparam int IDX_W = 19;
    localparam int BLEND_W = 7;
    localparam int CFG_DATA_W = 8;

    localparam int FRAME_PIXELS_DEFAULT = 307200;

    // BT.601-style luma weights, Q14
    localparam int LUMA_W = 22;
    localparam int LUMA_SHIFT = 14;
    localparam logic [LUMA_W-1:0] COEF_B = LUMA_W'(1868);
    localparam logic [LUMA_W-1:0] COEF_G = LUMA_W'(9617);
    localparam logic [LUMA_W-1:0] COEF_R = LUMA_W'(4899);
    localparam logic [LUMA_W-1:0] LUMA_ROUND = LUMA_W'(8192);

    // blend numerator (100-a)*bg + a*m fits in 15 bits (max 25500)
    localparam int NUM_W = 15;
    localparam logic [BLEND_W-1:0] PERCENT_FULL = BLEND_W'(100);
    localparam logic [PIX_W-1:0] MASK_ON = PIX_W'(255);
    localparam logic [PIX_W-1:0] HALF_PERCENT = PIX_W'(50);

    // floor(n/100) = (n * 5243) >> 19, exact for n < 2^15
    localparam int RECIP_W = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_W = 9;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = RECIP_W'(5243);

    typedef enum logic [0:0] {
        REG_BLEND_PERCENT  = 1'b0,
        REG_DIFF_THRESHOLD = 1'b1
    } cfg_reg_t;

    localparam logic [BLEND_W-1:0] BLEND_RESET = BLEND_W'(0);
    localparam logic [PIX_W-1:0] THRESH_RESET = PIX_W'(100);

endpackage

// ----- rtl/ramm_luma.sv -----
// Two-stage BGR to gray converter: products, then rounded Q14 sum.
// Depends on ramm_pkg.
module ramm_luma
    import ramm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [PIX_W-1:0] blue,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] red,
    output logic [PIX_W-1:0] gray
);

    logic [LUMA_W-1:0] prod_b_reg;
    logic [LUMA_W-1:0] prod_g_reg;
    logic [LUMA_W-1:0] prod_r_reg;
    logic [LUMA_W-1:0] sum_next;
    logic [PIX_W-1:0]  gray_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_b_reg <= LUMA_W'(blue) * COEF_B;
            prod_g_reg <= LUMA_W'(green) * COEF_G;
            prod_r_reg <= LUMA_W'(red) * COEF_R;
        end
    end

    // weights sum to 2^14, so the total never overflows 22 bits
    assign sum_next = prod_b_reg + prod_g_reg + prod_r_reg + LUMA_ROUND;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gray_reg <= sum_next[LUMA_SHIFT+PIX_W-1:LUMA_SHIFT];
        end
    end

    assign gray = gray_reg;

endmodule

// ----- rtl/running_average_motion_mask_core.sv -----
// Top level of the running average motion mask: pipeline, background store, config.
// Depends on ramm_pkg and ramm_luma.
//
// Usage
//   Input channel (in_valid/in_stall): one BGR pixel, its raster index and a
//   capture flag per transaction. A capture transaction writes the pixel's gray
//   level into the background store and yields no result. Any other
//   transaction yields one result: the motion bit, the blended background
//   value (also written back) and the index.
//   Output channel (out_valid/out_stall): one result per transaction.
//   Config channel (cfg_valid/cfg_ready): index 0 blend percent (above 100
//   acts as 100), index 1 difference threshold. Always ready; write only
//   while the block is idle.
// Pipeline: an accepted transaction passes stages 1 to 5, and its result is then
//   loaded into the output register.
// Throughput: one pixel per cycle while in_stall is low. The background store is
//   read at accept and written back when the item leaves stage 5, so a pixel
//   whose index matches an in-range item still in stages 1..5 is held off
//   (in_stall) until that write lands.
// Reset: config goes to blend 0, threshold 100; pipeline empties. The store
//   has no reset and no clearing pass: capture each pixel before using it.
// Receiver stall: the output register holds its result; the pipeline keeps
//   moving until a result-bearing item reaches stage 5, then freezes.
module running_average_motion_mask_core
    import ramm_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      blue,
    input  logic [PIX_W-1:0]      green,
    input  logic [PIX_W-1:0]      red,
    input  logic [IDX_W-1:0]      pixel_index,
    input  logic                  capture_background,
    // result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  motion,
    output logic [PIX_W-1:0]      background_value,
    output logic [IDX_W-1:0]      out_index,
    // config writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    // control that travels with every item
    typedef struct packed {
        logic             valid;
        logic             cap;
        logic             in_range;
        logic [IDX_W-1:0] idx;
    } tag_t;

    // ---------------- configuration ----------------
    logic [BLEND_W-1:0] blend_reg;
    logic [PIX_W-1:0]   thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg  <= BLEND_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLEND_PERCENT:  blend_reg  <= cfg_data[BLEND_W-1:0];
                REG_DIFF_THRESHOLD: thresh_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- pipeline registers ----------------
    tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;

    logic [PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0] y2;
    logic [PIX_W-1:0] bg2_reg, bg3_reg;
    logic [PIX_W-1:0] y3_reg, y4_reg, y5_reg;
    logic             moving3_reg, moving4_reg, moving5_reg;
    logic [NUM_W-1:0] num4_reg, num5_reg;
    logic [QUOT_W-1:0] quot5_reg;

    logic             out_valid_reg;
    logic             motion_reg;
    logic [PIX_W-1:0] bgval_reg;
    logic [IDX_W-1:0] out_index_reg;

    // ---------------- flow control ----------------
    logic pipe_en;
    logic out_load;
    logic hazard;
    logic in_accept;
    logic in_range_in;

    // freeze only when a result is stuck in the output and another is behind it
    assign out_load = !out_valid_reg || !out_stall;
    assign pipe_en  = out_load || !(tag5_reg.valid && !tag5_reg.cap);

    assign in_range_in = 32'(pixel_index) < 32'(FRAME_PIXELS);

    // read-after-write interlock on the background store
    always_comb
    begin
        hazard = 1'b0;
        if (in_range_in)
        begin
            if (tag1_reg.valid && tag1_reg.in_range && tag1_reg.idx == pixel_index)
                hazard = 1'b1;
            if (tag2_reg.valid && tag2_reg.in_range && tag2_reg.idx == pixel_index)
                hazard = 1'b1;
            if (tag3_reg.valid && tag3_reg.in_range && tag3_reg.idx == pixel_index)
                hazard = 1'b1;
            if (tag4_reg.valid && tag4_reg.in_range && tag4_reg.idx == pixel_index)
                hazard = 1'b1;
            if (tag5_reg.valid && tag5_reg.in_range && tag5_reg.idx == pixel_index)
                hazard = 1'b1;
        end
    end

    assign in_stall  = !pipe_en || hazard;
    assign in_accept = in_valid && !in_stall;

    // ---------------- background store ----------------
    logic [PIX_W-1:0] bg_mem [FRAME_PIXELS];
    logic [XW-1:0]    rd_wide;
    logic [XW-1:0]    wr_wide;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic [PIX_W-1:0] wr_data;

    assign rd_wide = XW'(pixel_index);
    assign rd_addr = rd_wide[AW-1:0];
    assign wr_wide = XW'(tag5_reg.idx);
    assign wr_addr = wr_wide[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            rd_data_reg <= bg_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            bg_mem[wr_addr] <= wr_data;
    end

    // ---------------- stage 1/2: gray conversion ----------------
    ramm_luma u_luma (
        .clk   (clk),
        .en    (pipe_en),
        .blue  (blue),
        .green (green),
        .red   (red),
        .gray  (y2)
    );

    tag_t tag1_next;

    always_comb
    begin
        tag1_next.valid    = in_accept;
        tag1_next.cap      = capture_background;
        tag1_next.in_range = in_range_in;
        tag1_next.idx      = pixel_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else if (pipe_en)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    // stage 2: background, zero when the index is outside the frame
    always_ff @(posedge clk)
    begin
        if (pipe_en)
            bg2_reg <= tag1_reg.in_range ? rd_data_reg : '0;
    end

    // ---------------- stage 3: difference and motion test ----------------
    logic [PIX_W-1:0] diff_next;

    assign diff_next = (bg2_reg > y2) ? (bg2_reg - y2) : (y2 - bg2_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            bg3_reg     <= bg2_reg;
            y3_reg      <= y2;
            moving3_reg <= diff_next > thresh_reg;
        end
    end

    // ---------------- stage 4: blend numerator ----------------
    logic [BLEND_W-1:0] alpha;
    logic [BLEND_W-1:0] alpha_inv;
    logic [NUM_W-1:0]   num_next;

    assign alpha     = (blend_reg > PERCENT_FULL) ? PERCENT_FULL : blend_reg;
    assign alpha_inv = PERCENT_FULL - alpha;
    assign num_next  = NUM_W'(alpha_inv) * NUM_W'(bg3_reg)
                     + (moving3_reg ? NUM_W'(alpha) * NUM_W'(MASK_ON) : '0);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            y4_reg      <= y3_reg;
            moving4_reg <= moving3_reg;
            num4_reg    <= num_next;
        end
    end

    // ---------------- stage 5: truncated quotient by 100 ----------------
    logic [NUM_W+RECIP_W-1:0] recip_prod;

    assign recip_prod = (NUM_W+RECIP_W)'(num4_reg) * (NUM_W+RECIP_W)'(DIV100_RECIP);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            y5_reg      <= y4_reg;
            moving5_reg <= moving4_reg;
            num5_reg    <= num4_reg;
            quot5_reg   <= recip_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        end
    end

    // ---------------- stage 6: round half to even, write back, output ----------------
    logic [NUM_W-1:0]  rem_wide;
    logic [PIX_W-1:0]  rem;
    logic              round_up;
    logic [QUOT_W-1:0] quot_rnd;
    logic [PIX_W-1:0]  new_bg;

    assign rem_wide = num5_reg - NUM_W'(quot5_reg) * NUM_W'(PERCENT_FULL);
    assign rem      = rem_wide[PIX_W-1:0];
    assign round_up = (rem > HALF_PERCENT) || (rem == HALF_PERCENT && quot5_reg[0]);
    assign quot_rnd = quot5_reg + QUOT_W'(round_up);
    assign new_bg   = (quot_rnd > QUOT_W'(MASK_ON)) ? MASK_ON : quot_rnd[PIX_W-1:0];

    assign wr_en   = pipe_en && tag5_reg.valid && tag5_reg.in_range;
    assign wr_data = tag5_reg.cap ? y5_reg : new_bg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= tag5_reg.valid && !tag5_reg.cap;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            motion_reg    <= moving5_reg;
            bgval_reg     <= new_bg;
            out_index_reg <= tag5_reg.idx;
        end
    end

    assign out_valid        = out_valid_reg;
    assign motion           = motion_reg;
    assign background_value = bgval_reg;
    assign out_index        = out_index_reg;

    // ---------------- assertions ----------------
    logic [4:0] same_as_wb;

    assign same_as_wb[0] = tag1_reg.valid && tag1_reg.in_range && tag1_reg.idx == tag5_reg.idx;
    assign same_as_wb[1] = tag2_reg.valid && tag2_reg.in_range && tag2_reg.idx == tag5_reg.idx;
    assign same_as_wb[2] = tag3_reg.valid && tag3_reg.in_range && tag3_reg.idx == tag5_reg.idx;
    assign same_as_wb[3] = tag4_reg.valid && tag4_reg.in_range && tag4_reg.idx == tag5_reg.idx;
    assign same_as_wb[4] = tag5_reg.valid && tag5_reg.in_range;

    // interlock: never two in-flight writers of the same pixel
    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        same_as_wb[4] |-> $onehot(same_as_wb))
        else $error("two in-flight items target the same background entry");

    // a result stuck behind a stalled output must not be overwritten
    a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && tag5_reg.valid && !tag5_reg.cap
        |=> tag5_reg.valid && $stable(tag5_reg.idx) && $stable(num5_reg))
        else $error("stage 5 result lost while output stalled");

    // no store write and no input taken while the pipeline is frozen
    a_no_write_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |-> !wr_en && in_stall)
        else $error("store written or input taken while pipeline frozen");

endmodule

// ----- bench/running_average_motion_mask_core_tb.sv -----
// Self-checking bench for running_average_motion_mask_core: luma, capture, motion
// test and blended background write-back, under several idle and stall patterns.
// Depends on rtl/ramm_pkg.sv and rtl/running_average_motion_mask_core.sv.
module running_average_motion_mask_core_tb
    import ramm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_LEN = FRAME_PIXELS_DEFAULT;
    localparam int unsigned IDX_TOP = (1 << IDX_W) - 1;
    // covers the path from accept to the output register, with margin on top
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT = 20000;
    localparam int POOL_DEPTH = 64;

    typedef struct packed {
        logic             motion;
        logic [PIX_W-1:0] bg_level;
        logic [IDX_W-1:0] index;
    } mask_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      blue = '0;
    logic [PIX_W-1:0]      green = '0;
    logic [PIX_W-1:0]      red = '0;
    logic [IDX_W-1:0]      pixel_index = '0;
    logic                  capture_background = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  motion;
    logic [PIX_W-1:0]      background_value;
    logic [IDX_W-1:0]      out_index;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_BLEND_PERCENT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Bench copy of the block state: configuration and the background frame.
    // Only entries that have been written exist in the associative array.
    logic [BLEND_W-1:0]    blend_weight = BLEND_RESET;
    logic [PIX_W-1:0]      motion_thresh = THRESH_RESET;
    logic [PIX_W-1:0]      bg_frame [bit [IDX_W-1:0]];
    // in-range indices with a known background, candidates for updates
    logic [IDX_W-1:0]      known_pixels [$];
    logic [IDX_W-1:0]      last_index = '0;

    mask_result_t          awaited_results [$];
    int                    mismatches = 0;
    int unsigned           idle_pct = 0;
    int unsigned           stall_pct = 0;

    running_average_motion_mask_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .blue               (blue),
        .green              (green),
        .red                (red),
        .pixel_index        (pixel_index),
        .capture_background (capture_background),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .motion             (motion),
        .background_value   (background_value),
        .out_index          (out_index),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #1_000_000;
        $display("running_average_motion_mask_core_tb NOT OK");
        $finish;
    end

    // Receiver back-pressure; the stall percentage is set per traffic phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Works out what one accepted pixel transaction does to the background
    // frame and, for non-capture transactions, queues the result it yields.
    function automatic void blend_background(input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] r,
                                             input logic [IDX_W-1:0] idx,
                                             input logic cap);
        int unsigned  luma;
        int unsigned  bg;
        int unsigned  diff;
        int unsigned  weight;
        int unsigned  num;
        int unsigned  quot;
        int unsigned  rem;
        bit           in_frame;
        bit           moving;
        mask_result_t res;

        in_frame = (idx < FRAME_LEN);
        // coefficients sum to 2^14, so a grey pixel maps to itself
        luma = (1868 * int'(b) + 9617 * int'(g) + 4899 * int'(r) + 8192) >> LUMA_SHIFT;

        if (cap)
        begin
            // capture outside the frame is dropped
            if (in_frame)
            begin
                if (!bg_frame.exists(idx))
                begin
                    known_pixels.push_back(idx);
                    if (known_pixels.size() > POOL_DEPTH)
                        void'(known_pixels.pop_front());
                end
                bg_frame[idx] = luma[PIX_W-1:0];
            end
            return;
        end

        // out-of-frame pixels compare against a black background
        bg = in_frame ? int'(bg_frame[idx]) : 0;
        diff = (bg > luma) ? bg - luma : luma - bg;
        moving = (diff > int'(motion_thresh));
        weight = (blend_weight > PERCENT_FULL) ? int'(PERCENT_FULL) : int'(blend_weight);
        num = (100 - weight) * bg + weight * (moving ? 255 : 0);
        quot = num / 100;
        rem = num % 100;
        // round half to even
        if (rem > 50 || (rem == 50 && quot[0]))
            quot++;
        if (quot > 255)
            quot = 255;
        if (in_frame)
            bg_frame[idx] = quot[PIX_W-1:0];

        res.motion = moving;
        res.bg_level = quot[PIX_W-1:0];
        res.index = idx;
        awaited_results.push_back(res);
    endfunction

    // One pixel transaction: optional idle cycles first, then hold the
    // payload until it is taken. in_valid stays high on return so that
    // back-to-back transactions never lower and raise it in one step.
    task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r, input logic [IDX_W-1:0] idx,
                              input logic cap);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        blue <= b;
        green <= g;
        red <= r;
        pixel_index <= idx;
        capture_background <= cap;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        blend_background(b, g, r, idx, cap);
    endtask

    // Register write, only once the pipeline is empty. Capture transactions
    // give no result, so allow the full latency after the last result.
    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (sel)
            REG_BLEND_PERCENT:  blend_weight = value[BLEND_W-1:0];
            REG_DIFF_THRESHOLD: motion_thresh = value;
            default: ;
        endcase
    endtask

    // Reset configuration: blend 0 leaves the background untouched, so the
    // motion decision is seen in isolation, including the exact threshold.
    task automatic test_default_config();
        send_pixel(8'd0, 8'd0, 8'd0, 19'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 19'(FRAME_LEN - 1), 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 19'd1, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 19'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 19'(FRAME_LEN - 1), 1'b0);
        // difference equal to the threshold is not motion; one above is
        send_pixel(8'd100, 8'd100, 8'd100, 19'd0, 1'b0);
        send_pixel(8'd101, 8'd101, 8'd101, 19'd0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 19'd1, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 19'd1, 1'b0);
    endtask

    // Indices past the frame: capture is dropped, update sees a black background.
    task automatic test_out_of_range();
        send_pixel(8'd255, 8'd255, 8'd255, 19'(FRAME_LEN), 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 19'(FRAME_LEN), 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 19'(IDX_TOP), 1'b0);
    endtask

    // Full and saturated blend weights, then half weight for the
    // round-half-to-even cases in both mask directions.
    task automatic test_blend_weights();
        write_reg(REG_BLEND_PERCENT, 8'd100);
        write_reg(REG_DIFF_THRESHOLD, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 19'd0, 1'b0);
        send_pixel(8'd1, 8'd1, 8'd1, 19'd0, 1'b0);
        // 127 acts as 100; threshold 255 can never be exceeded
        write_reg(REG_BLEND_PERCENT, 8'd127);
        write_reg(REG_DIFF_THRESHOLD, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0, 19'd0, 1'b0);
        write_reg(REG_BLEND_PERCENT, 8'd50);
        write_reg(REG_DIFF_THRESHOLD, 8'd128);
        // grey 1 halves to a tie rounding down, grey 3 to a tie rounding up
        send_pixel(8'd0, 8'd1, 8'd0, 19'd2, 1'b1);
        send_pixel(8'd0, 8'd1, 8'd0, 19'd2, 1'b0);
        send_pixel(8'd0, 8'd5, 8'd0, 19'd3, 1'b1);
        send_pixel(8'd0, 8'd5, 8'd0, 19'd3, 1'b0);
        // moving pixel on a black background: 127.5 rounds to 128
        send_pixel(8'd255, 8'd255, 8'd255, 19'd0, 1'b0);
    endtask

    // Mostly updates of pixels with a known background, often the same index
    // back to back to exercise the store hazard; some captures, some noise
    // past the frame. Returns whether the block does anything with it.
    task automatic send_random_pixel(output bit counted);
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
        logic [IDX_W-1:0] idx;
        logic             cap;
        int unsigned      pick;
        int               level;

        b = 8'($urandom);
        g = 8'($urandom);
        r = 8'($urandom);
        pick = $urandom_range(99);
        counted = 1'b1;
        if (pick < 15 || known_pixels.size() == 0)
        begin
            cap = 1'b1;
            case ($urandom_range(3))
                0: idx = 19'($urandom_range(15));
                1: idx = (last_index < FRAME_LEN) ? last_index : 19'd0;
                default: idx = 19'($urandom_range(FRAME_LEN - 1));
            endcase
        end
        else if (pick < 20)
        begin
            cap = 1'b1;
            idx = 19'($urandom_range(IDX_TOP, FRAME_LEN));
            counted = 1'b0;
        end
        else if (pick < 25)
        begin
            cap = 1'b0;
            idx = 19'($urandom_range(IDX_TOP, FRAME_LEN));
        end
        else
        begin
            cap = 1'b0;
            if ($urandom_range(99) < 40 && bg_frame.exists(last_index))
                idx = last_index;
            else
                idx = known_pixels[$urandom_range(known_pixels.size() - 1)];
            // grey close to the background keeps motion decisions mixed
            if ($urandom_range(99) < 30)
            begin
                level = int'(bg_frame[idx]) - 30 + int'($urandom_range(60));
                if (level < 0)
                    level = 0;
                if (level > 255)
                    level = 255;
                b = 8'(level);
                g = 8'(level);
                r = 8'(level);
            end
        end
        last_index = idx;
        send_pixel(b, g, r, idx, cap);
    endtask

    // Eight phases, each with its own register setting, cycling through four idle
    // patterns: none, sender idle, receiver stalling, both.
    task automatic test_random_traffic(input int per_phase);
        logic [CFG_DATA_W-1:0] blend_set [8] = '{8'd25, 8'd100, 8'd0, 8'd127,
                                                 8'd50, 8'd1, 8'd101, 8'd99};
        logic [CFG_DATA_W-1:0] thresh_set [8] = '{8'd100, 8'd0, 8'd255, 8'd30,
                                                  8'd128, 8'd5, 8'd200, 8'd60};
        int  done;
        bit  counted;

        for (int phase = 0; phase < 8; phase++)
        begin
            idle_pct = 0;
            stall_pct = 0;
            write_reg(REG_BLEND_PERCENT,
                      (phase == 7) ? 8'($urandom_range(127)) : blend_set[phase]);
            write_reg(REG_DIFF_THRESHOLD,
                      (phase == 7) ? 8'($urandom_range(255)) : thresh_set[phase]);
            case (phase % 4)
                1: idle_pct = 57;
                2: stall_pct = 57;
                3:
                begin
                    idle_pct = 36;
                    stall_pct = 36;
                end
                default: ;
            endcase
            done = 0;
            while (done < per_phase)
            begin
                send_random_pixel(counted);
                if (counted)
                    done++;
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // Result checker: every transaction on the output is matched against the
    // oldest awaited result, field by field.
    always @(posedge clk)
    begin
        mask_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result: motion %0b background %0d index %0d",
                         $time, motion, background_value, out_index);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (motion !== want.motion)
                begin
                    $display("%0t: motion expected %0b, actual %0b (index %0d)",
                             $time, want.motion, motion, want.index);
                    mismatches++;
                end
                if (background_value !== want.bg_level)
                begin
                    $display("%0t: background expected %0d, actual %0d (index %0d)",
                             $time, want.bg_level, background_value, want.index);
                    mismatches++;
                end
                if (out_index !== want.index)
                begin
                    $display("%0t: index expected %0d, actual %0d",
                             $time, want.index, out_index);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_config();
        test_out_of_range();
        test_blend_weights();
        test_random_traffic(235);

        // drain: let every awaited result arrive, then a few spare cycles
        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && awaited_results.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived, first index %0d",
                     $time, awaited_results.size(), awaited_results[0].index);
            mismatches++;
        end

        if (mismatches == 0)
            $display("running_average_motion_mask_core_tb OK");
        else
            $display("running_average_motion_mask_core_tb NOT OK");
        $finish;
    end

endmodule
